### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers for the RTL checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define MCOC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mcoc: assertion failed");

// Assertion sampled on the rising clock edge at all times, reset included.
`define MCOC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mcoc: assertion failed");

`endif

### rtl/core/mcoc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix chain order cost package
// Field widths, status codes and the split-issue control struct.
// ---------------------------------------------------------------------------
package mcoc_pkg;

   localparam int DIM_W            = 12;
   localparam int COST_OUT_W       = 42;
   localparam int SPLIT_W          = 7;
   localparam int STATUS_W         = 2;
   localparam int REQ_DATA_W       = 16;
   localparam int RSP_DATA_W       = 56;
   localparam int MAX_MATRICES_DEF = 64;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_SHORT    = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   // One split candidate sent to the evaluation pipe
   typedef struct packed {
      logic               issue;
      logic               zero_left;
      logic               zero_right;
      logic [SPLIT_W-1:0] split;
   } mcoc_issue_type;

endpackage

### rtl/core/mcoc_dim_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimension store
// Synchronous memory for the chain's dimensions, one write and two reads.
// ---------------------------------------------------------------------------
module mcoc_dim_store #(
   parameter int  MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
   localparam int AddrW        = $clog2(MAX_MATRICES + 1)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AddrW-1:0]           wr_addr,
   input  logic [mcoc_pkg::DIM_W-1:0] wr_data,
   input  logic [AddrW-1:0]           rd_addr_a,
   input  logic [AddrW-1:0]           rd_addr_b,
   output logic [mcoc_pkg::DIM_W-1:0] rd_data_a,
   output logic [mcoc_pkg::DIM_W-1:0] rd_data_b
);
   import mcoc_pkg::*;

   localparam int Depth = MAX_MATRICES + 1;

   logic [DIM_W-1:0] mem [Depth];
   logic [DIM_W-1:0] rd_data_a_ff;
   logic [DIM_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/core/mcoc_cost_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cost table
// Synchronous memory for subchain costs, addressed by row and column.
// ---------------------------------------------------------------------------
module mcoc_cost_table #(
   parameter int  MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
   localparam int IdxW         = $clog2(MAX_MATRICES),
   localparam int CostW        = 3 * mcoc_pkg::DIM_W + $clog2(MAX_MATRICES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IdxW-1:0]  wr_row,
   input  logic [IdxW-1:0]  wr_col,
   input  logic [CostW-1:0] wr_data,
   input  logic [IdxW-1:0]  rd_row_a,
   input  logic [IdxW-1:0]  rd_col_a,
   input  logic [IdxW-1:0]  rd_row_b,
   input  logic [IdxW-1:0]  rd_col_b,
   output logic [CostW-1:0] rd_data_a,
   output logic [CostW-1:0] rd_data_b
);
   import mcoc_pkg::*;

   localparam int Depth = 1 << (2 * IdxW);

   logic [CostW-1:0] mem [Depth];
   logic [CostW-1:0] rd_data_a_ff;
   logic [CostW-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_row, wr_col}] <= wr_data;
      end
      rd_data_a_ff <= mem[{rd_row_a, rd_col_a}];
      rd_data_b_ff <= mem[{rd_row_b, rd_col_b}];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/core/mcoc_split_eval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Split evaluation pipe
// Adds left cost, right cost and the dimension product for each split and
// keeps the cheapest one, lowest split first on ties.
// ---------------------------------------------------------------------------
module mcoc_split_eval #(
   parameter int  MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF,
   localparam int CostW        = 3 * mcoc_pkg::DIM_W + $clog2(MAX_MATRICES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  mcoc_pkg::mcoc_issue_type        issue,
   input  logic [2*mcoc_pkg::DIM_W-1:0]    pair_prod,
   input  logic [mcoc_pkg::DIM_W-1:0]      dim_k,
   input  logic [CostW-1:0]                cost_left,
   input  logic [CostW-1:0]                cost_right,
   output logic                            busy,
   output logic [CostW-1:0]                best_cost,
   output logic [mcoc_pkg::SPLIT_W-1:0]    best_split
);
   import mcoc_pkg::*;

   localparam int ProdW = 3 * DIM_W;

   mcoc_issue_type     ctl_ff;
   logic               v1_ff, v2_ff;
   logic [SPLIT_W-1:0] split1_ff, split2_ff;
   logic [CostW-1:0]   sum_ff, sum_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic [CostW-1:0]   cand_ff, cand_in;
   logic [CostW-1:0]   best_ff, best_in;
   logic [SPLIT_W-1:0] best_split_ff, best_split_in;
   logic [CostW-1:0]   left_term, right_term;

   // diagonal entries are zero and never stored
   assign left_term  = ctl_ff.zero_left  ? '0 : cost_left;
   assign right_term = ctl_ff.zero_right ? '0 : cost_right;
   assign sum_in     = left_term + right_term;
   assign prod_in    = {{DIM_W{1'b0}}, pair_prod} * {{(2*DIM_W){1'b0}}, dim_k};
   assign cand_in    = sum_ff + CostW'(prod_ff);

   always_comb begin
      best_in       = best_ff;
      best_split_in = best_split_ff;
      if (start) begin
         best_in       = '1;
         best_split_in = '0;
      end else if (v2_ff && (cand_ff < best_ff)) begin
         best_in       = cand_ff;
         best_split_in = split2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         ctl_ff <= issue;
         v1_ff  <= ctl_ff.issue;
         v2_ff  <= v1_ff;
      end
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      split1_ff     <= ctl_ff.split;
      cand_ff       <= cand_in;
      split2_ff     <= split1_ff;
      best_ff       <= best_in;
      best_split_ff <= best_split_in;
   end

   assign busy       = ctl_ff.issue | v1_ff | v2_ff;
   assign best_cost  = best_ff;
   assign best_split = best_split_ff;

endmodule

### rtl/core/matrix_chain_order_cost_unit.sv
`timescale 1ns / 1ps
// Load: one dimension a cycle while req_tready is high, which is only in the
//   load state; it is low from a chain's last dimension until its result is output.
// Fill of n matrices: each table entry of length L takes a dimension read, a
//   dimension product, L - 1 split reads and a drain of the add/compare pipe.
// Result: held in the result registers, then moved to the output registers
//   when they are free. Synchronous reset clears control only; no clearing pass.
// ---------------------------------------------------------------------------
// Matrix chain order cost unit
// Loads a dimension list and fills the triangular cost table to give the
// cheapest multiplication order of the chain.
// ---------------------------------------------------------------------------
module matrix_chain_order_cost_unit #(
   parameter int MAX_MATRICES = mcoc_pkg::MAX_MATRICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mcoc_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] dimension
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mcoc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [41:0] min_cost, [48:42] root_split
   output logic [mcoc_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);
   import mcoc_pkg::*;

   localparam int Slots = MAX_MATRICES + 1;
   localparam int CntW  = $clog2(MAX_MATRICES + 2);
   localparam int DIdxW = $clog2(MAX_MATRICES + 1);
   localparam int LenW  = $clog2(MAX_MATRICES + 1);
   localparam int IdxW  = $clog2(MAX_MATRICES);
   localparam int CostW = 3 * DIM_W + $clog2(MAX_MATRICES);

   localparam logic [2:0] ST_LOAD    = 3'd0;
   localparam logic [2:0] ST_DIM_RD  = 3'd1;
   localparam logic [2:0] ST_DIM_MUL = 3'd2;
   localparam logic [2:0] ST_SPLIT   = 3'd3;
   localparam logic [2:0] ST_DRAIN   = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [LenW-1:0]       nm_ff, nm_in;
   logic [LenW-1:0]       len_ff, len_in;
   logic [IdxW-1:0]       a_ff, a_in;
   logic [IdxW-1:0]       b_ff, b_in;
   logic [IdxW-1:0]       k_ff, k_in;
   logic [2*DIM_W-1:0]    pair_prod_ff, pair_prod_in;
   logic [COST_OUT_W-1:0] res_cost_ff, res_cost_in;
   logic [SPLIT_W-1:0]    res_split_ff, res_split_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COST_OUT_W-1:0] rsp_cost_ff;
   logic [SPLIT_W-1:0]    rsp_split_ff;
   status_type            rsp_status_ff;

   logic                  req_fire, store_ok, rsp_load;
   logic [IdxW-1:0]       k_next;
   logic                  dim_wr_en;
   logic [DIdxW-1:0]      dim_addr_a, dim_addr_b;
   logic [DIM_W-1:0]      dim_data_a, dim_data_b;
   logic                  cost_wr_en;
   logic [CostW-1:0]      cost_left, cost_right;
   mcoc_issue_type        issue;
   logic                  eval_busy;
   logic [CostW-1:0]      best_cost;
   logic [SPLIT_W-1:0]    best_split;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign store_ok   = (count_ff < CntW'(Slots));
   assign dim_wr_en  = req_fire & store_ok;
   assign k_next     = k_ff + IdxW'(1);
   assign rsp_load   = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_tready);

   assign dim_addr_a = (state_ff == ST_SPLIT) ? DIdxW'(k_next) : DIdxW'(a_ff);
   assign dim_addr_b = DIdxW'(b_ff) + DIdxW'(1);

   assign issue.issue      = (state_ff == ST_SPLIT);
   assign issue.zero_left  = (k_ff == a_ff);
   assign issue.zero_right = (k_next == b_ff);
   assign issue.split      = SPLIT_W'(k_next);

   assign cost_wr_en = (state_ff == ST_DRAIN) & ~eval_busy;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      nm_in         = nm_ff;
      len_in        = len_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      pair_prod_in  = pair_prod_ff;
      res_cost_in   = res_cost_ff;
      res_split_in  = res_split_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               count_in    = store_ok ? count_ff + CntW'(1) : count_ff;
               overflow_in = overflow_ff | ~store_ok;
               if (req_tlast) begin
                  count_in      = '0;
                  overflow_in   = 1'b0;
                  res_cost_in   = '0;
                  res_split_in  = '0;
                  res_status_in = STATUS_OK;
                  state_in      = ST_DONE;
                  if (overflow_ff | ~store_ok) begin
                     res_status_in = STATUS_OVERFLOW;
                  end else if (count_ff == '0) begin
                     res_status_in = STATUS_SHORT;
                  end else if (count_ff != CntW'(1)) begin
                     // two or more matrices: fill the table
                     nm_in    = LenW'(count_ff);
                     len_in   = LenW'(2);
                     a_in     = '0;
                     b_in     = IdxW'(1);
                     state_in = ST_DIM_RD;
                  end
               end
            end
         end
         ST_DIM_RD: begin
            state_in = ST_DIM_MUL;
         end
         ST_DIM_MUL: begin
            pair_prod_in = {{DIM_W{1'b0}}, dim_data_a} * {{DIM_W{1'b0}}, dim_data_b};
            k_in         = a_ff;
            state_in     = ST_SPLIT;
         end
         ST_SPLIT: begin
            k_in = k_next;
            if (k_next == b_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!eval_busy) begin
               if (len_ff == nm_ff) begin
                  res_cost_in   = COST_OUT_W'(best_cost);
                  res_split_in  = best_split;
                  res_status_in = STATUS_OK;
                  state_in      = ST_DONE;
               end else if ((LenW'(b_ff) + LenW'(1)) != nm_ff) begin
                  a_in     = a_ff + IdxW'(1);
                  b_in     = b_ff + IdxW'(1);
                  state_in = ST_DIM_RD;
               end else begin
                  // next length: first entry ends at column len
                  len_in   = len_ff + LenW'(1);
                  a_in     = '0;
                  b_in     = IdxW'(len_ff);
                  state_in = ST_DIM_RD;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nm_ff         <= nm_in;
      len_ff        <= len_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      k_ff          <= k_in;
      pair_prod_ff  <= pair_prod_in;
      res_cost_ff   <= res_cost_in;
      res_split_ff  <= res_split_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_cost_ff   <= res_cost_ff;
         rsp_split_ff  <= res_split_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   mcoc_dim_store #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_dim_store (
      .clock     (clock),
      .wr_en     (dim_wr_en),
      .wr_addr   (count_ff[DIdxW-1:0]),
      .wr_data   (req_tdata[DIM_W-1:0]),
      .rd_addr_a (dim_addr_a),
      .rd_addr_b (dim_addr_b),
      .rd_data_a (dim_data_a),
      .rd_data_b (dim_data_b)
   );

   mcoc_cost_table #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_cost_table (
      .clock     (clock),
      .wr_en     (cost_wr_en),
      .wr_row    (a_ff),
      .wr_col    (b_ff),
      .wr_data   (best_cost),
      .rd_row_a  (a_ff),
      .rd_col_a  (k_ff),
      .rd_row_b  (k_next),
      .rd_col_b  (b_ff),
      .rd_data_a (cost_left),
      .rd_data_b (cost_right)
   );

   mcoc_split_eval #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_split_eval (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == ST_DIM_MUL),
      .issue      (issue),
      .pair_prod  (pair_prod_ff),
      .dim_k      (dim_data_a),
      .cost_left  (cost_left),
      .cost_right (cost_right),
      .busy       (eval_busy),
      .best_cost  (best_cost),
      .best_split (best_split)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COST_OUT_W - SPLIT_W){1'b0}}, rsp_split_ff, rsp_cost_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/core/mcoc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix chain order cost checker
// Port-level assertions on the request and response channels.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mcoc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mcoc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mcoc_pkg::STATUS_W-1:0]   rsp_tuser
);
   import mcoc_pkg::*;

   // a stalled response holds
   `MCOC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `MCOC_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_SHORT || rsp_tuser == STATUS_OVERFLOW)
   // an error response carries no cost and no split
   `MCOC_ASSERT(a_error_zero, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
   // the end of a chain stops further requests until its result is formed
   `MCOC_ASSERT(a_last_stalls, clock, reset, req_tvalid && req_tready && req_tlast |=> !req_tready)
   `MCOC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)

endmodule

bind matrix_chain_order_cost_unit mcoc_checker u_mcoc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Matrix chain order cost unit testbench
// Streams dimension lists into the unit and checks each chain's minimum cost,
// outermost split and status against a cost table worked out in parallel.
// Directed chains cover the short, single-matrix, tie, zero and extreme
// cases. Random chains follow, mostly short ones with a few full or
// overflowing ones. Both sides idle at random, with one long result stall.
// ---------------------------------------------------------------------------
module tb;

   import mcoc_pkg::*;

   localparam int MAX_M          = MAX_MATRICES_DEF;
   localparam int DIM_SLOTS      = MAX_M + 1;
   localparam int ITEM_TARGET    = 650;
   localparam int HOLD_CYCLES    = 3000;
   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic [COST_OUT_W-1:0] min_cost;
      logic [SPLIT_W-1:0]    root_split;
      status_type            status;
   } chain_result_type;

   // Mirrors the unit: collects dimensions, solves the chain on its last one
   class chain_order_tracker;
      logic [DIM_W-1:0]  dims [0:DIM_SLOTS-1];
      logic [63:0]       cost_tab [0:MAX_M-1][0:MAX_M-1];
      int unsigned       dim_count;
      bit                overflow_seen;
      chain_result_type  pending_costs [$];
      int unsigned       errors;
      int unsigned       results_seen;

      function new();
         dim_count     = 0;
         overflow_seen = 0;
         errors        = 0;
         results_seen  = 0;
      endfunction

      function void solve_chain(input int unsigned nm, output logic [63:0] cost,
                                output logic [SPLIT_W-1:0] root);
         int unsigned        len, a, b, k;
         logic [63:0]        best, cand, pa, pk, pb;
         logic [SPLIT_W-1:0] best_k;
         root = '0;
         for (a = 0; a < nm; a++)
            cost_tab[a][a] = '0;
         for (len = 2; len <= nm; len++) begin
            for (a = 0; a + len <= nm; a++) begin
               b      = a + len - 1;
               best   = '1;
               best_k = '0;
               for (k = a; k < b; k++) begin
                  pa   = {{(64-DIM_W){1'b0}}, dims[a]};
                  pk   = {{(64-DIM_W){1'b0}}, dims[k+1]};
                  pb   = {{(64-DIM_W){1'b0}}, dims[b+1]};
                  cand = cost_tab[a][k] + cost_tab[k+1][b] + pa * pk * pb;
                  // strict compare: the lowest split wins a tie
                  if (cand < best) begin
                     best   = cand;
                     best_k = SPLIT_W'(k + 1);
                  end
               end
               cost_tab[a][b] = best;
               if (a == 0 && b == nm - 1)
                  root = best_k;
            end
         end
         cost = cost_tab[0][nm-1];
      endfunction

      function void take_dimension(input logic [DIM_W-1:0] dim, input logic last);
         chain_result_type   r;
         logic [63:0]        cost;
         logic [SPLIT_W-1:0] root;
         if (dim_count < DIM_SLOTS) begin
            dims[dim_count] = dim;
            dim_count++;
         end else begin
            overflow_seen = 1;
         end
         if (!last)
            return;
         r.min_cost   = '0;
         r.root_split = '0;
         if (overflow_seen) begin
            r.status = STATUS_OVERFLOW;
         end else if (dim_count < 2) begin
            r.status = STATUS_SHORT;
         end else begin
            r.status = STATUS_OK;
            solve_chain(dim_count - 1, cost, root);
            r.min_cost   = cost[COST_OUT_W-1:0];
            r.root_split = root;
         end
         pending_costs.push_back(r);
         dim_count     = 0;
         overflow_seen = 0;
      endfunction

      function void match_result(input logic [COST_OUT_W-1:0] cost,
                                 input logic [SPLIT_W-1:0] split, input status_type status);
         chain_result_type want;
         results_seen++;
         if (pending_costs.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: cost %0d split %0d status %0d",
                     $time, cost, split, status);
            return;
         end
         want = pending_costs.pop_front();
         if (cost !== want.min_cost) begin
            errors++;
            if (errors < 100)
               $display("%0t: min_cost expected %0d actual %0d", $time, want.min_cost, cost);
         end
         if (split !== want.root_split) begin
            errors++;
            if (errors < 100)
               $display("%0t: root_split expected %0d actual %0d",
                        $time, want.root_split, split);
         end
         if (status !== want.status) begin
            errors++;
            if (errors < 100)
               $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   chain_order_tracker tracker = new();
   logic [DIM_W-1:0]   chain_dims [$];
   bit                 quiet_sender;
   int unsigned        items_sent = 0;
   int unsigned        idle_cycles = 0;

   matrix_chain_order_cost_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_dimension(input logic [DIM_W-1:0] dim, input logic last);
      int unsigned r, gap;
      gap = 0;
      if (!quiet_sender) begin
         r = $urandom_range(0, 99);
         if (r >= 95)
            gap = $urandom_range(8, 40);
         else if (r >= 70)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-DIM_W){1'b0}}, dim};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_dimension(dim, last);
      items_sent++;
   endtask

   task automatic send_chain();
      int unsigned i;
      for (i = 0; i < chain_dims.size(); i++)
         send_dimension(chain_dims[i], i == chain_dims.size() - 1);
   endtask

   // Stimulus
   initial begin
      int unsigned chain_no, n, i, p, r;
      logic [DIM_W-1:0] d;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      quiet_sender = 0;
      chain_dims = '{12'd4095};                      send_chain();
      chain_dims = '{12'd0};                         send_chain();
      chain_dims = '{12'd7, 12'd4095};               send_chain();
      chain_dims = '{12'd1, 12'd4095, 12'd1};        send_chain();
      chain_dims = '{12'd2, 12'd2, 12'd2, 12'd2};    send_chain();
      chain_dims = '{12'd10, 12'd0, 12'd20, 12'd30}; send_chain();
      chain_dims = '{12'd10, 12'd30, 12'd5, 12'd60}; send_chain();
      chain_dims = '{12'd4095, 12'd4095, 12'd4095, 12'd4095};
      send_chain();

      chain_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (chain_no == 2 || chain_no == 9) begin
            n = DIM_SLOTS;
         end else if (chain_no == 5) begin
            n = DIM_SLOTS + $urandom_range(1, 6);
         end else begin
            p = $urandom_range(0, 99);
            if (p < 2)
               n = DIM_SLOTS + $urandom_range(1, 6);
            else if (p < 5)
               n = $urandom_range(20, DIM_SLOTS);
            else if (p < 22)
               n = $urandom_range(9, 19);
            else
               n = $urandom_range(1, 8);
         end
         quiet_sender = ($urandom_range(0, 3) == 0);
         chain_dims.delete();
         for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            // one full chain of top dimensions gives the largest cost
            if (chain_no == 2 || r < 3)
               d = (chain_no == 2) ? '1 : '0;
            else if (r < 6)
               d = '1;
            else if (r < 9)
               d = DIM_W'(1);
            else
               d = DIM_W'($urandom_range(0, 4095));
            chain_dims.push_back(d);
         end
         send_chain();
         chain_no++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (tracker.pending_costs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("[matrix_chain_order_cost_unit] OK");
      else
         $display("[matrix_chain_order_cost_unit] ERROR");
      $finish;
   end

   // Result side: random back-pressure and one long hold
   initial begin
      int unsigned stall_left, hold_left, mode_left, r;
      bit busy_mode, held_once;
      stall_left = 0;
      hold_left  = 0;
      mode_left  = 0;
      busy_mode  = 0;
      held_once  = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.match_result(rsp_tdata[COST_OUT_W-1:0],
                                 rsp_tdata[COST_OUT_W +: SPLIT_W], rsp_tuser);
         if (mode_left == 0) begin
            busy_mode = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(100, 400);
         end else begin
            mode_left--;
         end
         // hold off long enough for the unit to fill up and stall its input
         if (!held_once && tracker.results_seen >= 15) begin
            held_once = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!busy_mode) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               stall_left = $urandom_range(10, 60);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= (r >= 30);
            end
         end
      end
   end

   // Watchdog: count cycles in which no request and no result moves
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[matrix_chain_order_cost_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
